/* rtl/tsjm_pkg.sv */
// Shared types, codes and constants of the tick schedule jitter monitor.
package tsjm_pkg;

  localparam int unsigned SAMPLE_DEPTH = 64;

  // Nearest-rank percentile: rank = (n * 95 + 99) / 100, with the divide done
  // as a multiply by a reciprocal that is exact for n up to 256.
  localparam int unsigned P95_NUM         = 95;
  localparam int unsigned RANK_ROUND      = 99;
  localparam int unsigned RECIP_100       = 5243;
  localparam int unsigned RECIP_100_W     = 13;
  localparam int unsigned RECIP_100_SHIFT = 19;

  // n / 3 as (n * 171) >> 9, exact for n up to 256.
  localparam int unsigned RECIP_3       = 171;
  localparam int unsigned RECIP_3_W     = 8;
  localparam int unsigned RECIP_3_SHIFT = 9;

  localparam int unsigned MIN_SPLIT = 6;
  localparam int unsigned DIV_STEPS = 48;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 32;

  localparam logic [15:0] PERIOD_RESET      = 16'd50;
  localparam logic [31:0] WORK_BUDGET_RESET = 32'd10;
  localparam logic [31:0] P95_BUDGET_RESET  = 32'd8;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_RUN   = 2'd1,
    KIND_SKIP  = 2'd2,
    KIND_POLL  = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD      = 2'd0,
    REG_WORK_BUDGET = 2'd1,
    REG_P95_BUDGET  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    kind_t       kind;
    logic [47:0] now_ms;
    logic [31:0] work_ms;
    logic [31:0] skip_ticks;
  } in_t;

  typedef struct packed {
    logic [31:0] pending_ticks;
    logic        over_budget;
    logic [31:0] error_p95_ms;
    logic        meets_budget;
    logic [31:0] head_tail_gap_ms;
    logic [31:0] overrun_count;
    logic [31:0] skipped_total;
  } out_t;

  typedef enum logic [3:0] {
    C_IDLE,
    C_EXEC,
    C_LATE,
    C_DIV,
    C_PEND,
    C_ALL_GO,
    C_ALL_WAIT,
    C_HEAD_GO,
    C_HEAD_WAIT,
    C_TAIL_GO,
    C_TAIL_WAIT,
    C_DONE
  } ctrl_state_t;

  typedef enum logic [2:0] {
    SL_IDLE,
    SL_RANK,
    SL_READ,
    SL_SCAN,
    SL_DONE
  } sel_state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic late;
    logic div_step;
    logic pend;
    logic go_all;
    logic go_head;
    logic go_tail;
    logic take_all;
    logic take_head;
    logic take_tail;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  div_last;
    logic  sel_done;
    logic  fill_ge_split;
  } stat_t;

endpackage

/* rtl/tsjm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tsjm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/tsjm_sel.sv */
// Radix-16 selection engine: nearest-rank P95 of a run of ring slots.
module tsjm_sel #(
  parameter int unsigned DEPTH = tsjm_pkg::SAMPLE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [$clog2(DEPTH)-1:0]   first,
  input  logic [$clog2(DEPTH+1)-1:0] count,
  output logic [$clog2(DEPTH)-1:0]   rd_addr,
  input  logic [31:0]                rd_data,
  output logic                       done,
  output logic [31:0]                value
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam int unsigned XW = $clog2(DEPTH * tsjm_pkg::P95_NUM + tsjm_pkg::RANK_ROUND + 1);
  localparam int unsigned PW = XW + tsjm_pkg::RECIP_100_W;

  tsjm_pkg::sel_state_t state, state_next;

  logic [AW-1:0] first_q;
  logic [FW-1:0] cnt_n;
  logic [XW-1:0] x_q;
  logic [FW-1:0] rem;
  logic [2:0]    digit;
  logic [31:0]   prefix;
  logic [FW-1:0] idx;
  logic          rd_pend;
  logic [FW-1:0] cnt [16];
  logic [3:0]    bkt;
  logic [FW-1:0] cum;

  logic          issue;
  logic [FW:0]   addr_sum;
  logic [5:0]    shamt;
  logic [31:0]   hi_mask;
  logic          match;
  logic [3:0]    nib;
  logic [FW:0]   sum;
  logic          found;
  logic [PW-1:0] rank_prod;
  logic [FW-1:0] rank;

  always_comb begin
    issue     = (state == tsjm_pkg::SL_READ) && (idx < cnt_n);
    addr_sum  = (FW+1)'(first_q) + (FW+1)'(idx);
    rd_addr   = addr_sum[AW-1:0];
    // Bits above the current digit must equal the prefix chosen so far.
    shamt     = {1'b0, digit, 2'b00} + 6'd4;
    hi_mask   = 32'hFFFF_FFFF << shamt;
    match     = ((rd_data ^ prefix) & hi_mask) == 32'd0;
    nib       = rd_data[{digit, 2'b00} +: 4];
    sum       = (FW+1)'(cum) + (FW+1)'(cnt[bkt]);
    found     = sum >= (FW+1)'(rem);
    rank_prod = PW'(x_q) * PW'(tsjm_pkg::RECIP_100);
    rank      = FW'(rank_prod >> tsjm_pkg::RECIP_100_SHIFT);
    done      = state == tsjm_pkg::SL_DONE;
    value     = prefix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsjm_pkg::SL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tsjm_pkg::SL_IDLE: begin
        if (go) begin
          state_next = (count == '0) ? tsjm_pkg::SL_DONE : tsjm_pkg::SL_RANK;
        end
      end
      tsjm_pkg::SL_RANK: state_next = tsjm_pkg::SL_READ;
      tsjm_pkg::SL_READ: begin
        if (idx == cnt_n && !rd_pend) begin
          state_next = tsjm_pkg::SL_SCAN;
        end
      end
      tsjm_pkg::SL_SCAN: begin
        if (found) begin
          state_next = (digit == 3'd0) ? tsjm_pkg::SL_DONE : tsjm_pkg::SL_READ;
        end
      end
      tsjm_pkg::SL_DONE: state_next = tsjm_pkg::SL_IDLE;
      default:           state_next = tsjm_pkg::SL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      tsjm_pkg::SL_IDLE: begin
        if (go) begin
          first_q <= first;
          cnt_n   <= count;
          x_q     <= XW'(count) * XW'(tsjm_pkg::P95_NUM) + XW'(tsjm_pkg::RANK_ROUND);
          prefix  <= '0;
        end
      end
      tsjm_pkg::SL_RANK: begin
        rem     <= rank;
        digit   <= 3'd7;
        idx     <= '0;
        rd_pend <= 1'b0;
        for (int b = 0; b < 16; b++) begin
          cnt[b] <= '0;
        end
      end
      tsjm_pkg::SL_READ: begin
        rd_pend <= issue;
        if (issue) begin
          idx <= idx + FW'(1);
        end
        if (rd_pend && match) begin
          for (int b = 0; b < 16; b++) begin
            if (nib == 4'(b)) begin
              cnt[b] <= cnt[b] + FW'(1);
            end
          end
        end
        bkt <= '0;
        cum <= '0;
      end
      tsjm_pkg::SL_SCAN: begin
        if (found) begin
          prefix[{digit, 2'b00} +: 4] <= bkt;
          rem     <= rem - cum;
          digit   <= digit - 3'd1;
          idx     <= '0;
          rd_pend <= 1'b0;
          for (int b = 0; b < 16; b++) begin
            cnt[b] <= '0;
          end
        end else begin
          cum <= sum[FW-1:0];
          bkt <= bkt + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/tsjm_dp.sv */
// Datapath: schedule state, lateness ring, divider and percentile results.
module tsjm_dp #(
  parameter int unsigned DEPTH = tsjm_pkg::SAMPLE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  tsjm_pkg::in_t                      item,
  input  tsjm_pkg::cmd_t                     cmd,
  input  logic                               cfg_we,
  input  logic [tsjm_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [tsjm_pkg::CFG_W-1:0]         cfg_data,
  output tsjm_pkg::stat_t                    stat,
  output tsjm_pkg::out_t                     result
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam int unsigned TW = FW + tsjm_pkg::RECIP_3_W;

  tsjm_pkg::in_t item_q;

  logic [15:0] period_cfg;
  logic [31:0] work_budget;
  logic [31:0] p95_budget;

  logic [47:0]   start_time;
  logic [31:0]   tick_counter;
  logic [31:0]   overrun_cnt;
  logic [31:0]   skip_cnt;
  logic [AW-1:0] wr_slot;
  logic [FW-1:0] fill;
  logic [FW-1:0] third;

  logic [47:0] prod;
  logic [47:0] dq;
  logic [15:0] drem;
  logic [5:0]  div_cnt;
  logic        poll_ok;

  logic [31:0] pending;
  logic        over;
  logic [31:0] p95;
  logic        meets;
  logic [31:0] head_p95;
  logic [31:0] gap;

  logic [15:0] eff_period;
  logic [48:0] sched;
  logic [48:0] now_ext;
  logic [48:0] late;
  logic [31:0] late_sat;
  logic [16:0] trial;
  logic        trial_ge;
  logic [16:0] trial_sub;
  logic [48:0] due;
  logic [48:0] due_diff;
  logic [TW-1:0] third_prod;

  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_data;
  logic          sel_go;
  logic [AW-1:0] sel_first;
  logic [FW:0]   tail_first;
  logic [FW-1:0] sel_count;
  logic          sel_done;
  logic [31:0]   sel_value;

  always_comb begin
    eff_period = (period_cfg == 16'd0) ? 16'd1 : period_cfg;
    sched      = {1'b0, start_time} + {1'b0, prod};
    now_ext    = {1'b0, item_q.now_ms};
    late       = (now_ext >= sched) ? now_ext - sched : sched - now_ext;
    late_sat   = (late[48:32] != 17'd0) ? 32'hFFFF_FFFF : late[31:0];
    trial      = {drem, dq[47]};
    trial_ge   = trial >= {1'b0, eff_period};
    trial_sub  = trial - {1'b0, eff_period};
    due        = {1'b0, dq} + 49'd1;
    due_diff   = due - {17'd0, tick_counter};
    third_prod = TW'(fill) * TW'(tsjm_pkg::RECIP_3);
    tail_first = (FW+1)'(fill) - (FW+1)'(third);
    sel_go     = cmd.go_all | cmd.go_head | cmd.go_tail;
    sel_first  = cmd.go_tail ? tail_first[AW-1:0] : '0;
    sel_count  = cmd.go_all ? fill : third;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      period_cfg  <= tsjm_pkg::PERIOD_RESET;
      work_budget <= tsjm_pkg::WORK_BUDGET_RESET;
      p95_budget  <= tsjm_pkg::P95_BUDGET_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        tsjm_pkg::REG_PERIOD:      period_cfg  <= cfg_data[15:0];
        tsjm_pkg::REG_WORK_BUDGET: work_budget <= cfg_data;
        tsjm_pkg::REG_P95_BUDGET:  p95_budget  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Schedule and ring bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_time   <= '0;
      tick_counter <= '0;
      overrun_cnt  <= '0;
      skip_cnt     <= '0;
      wr_slot      <= '0;
      fill         <= '0;
    end else if (cmd.exec) begin
      unique case (item_q.kind)
        tsjm_pkg::KIND_START: begin
          start_time   <= item_q.now_ms;
          tick_counter <= '0;
          overrun_cnt  <= '0;
          skip_cnt     <= '0;
          wr_slot      <= '0;
          fill         <= '0;
        end
        tsjm_pkg::KIND_SKIP: skip_cnt <= skip_cnt + item_q.skip_ticks;
        tsjm_pkg::KIND_RUN,
        tsjm_pkg::KIND_POLL: begin
        end
        default: begin
        end
      endcase
    end else if (cmd.late) begin
      wr_slot      <= (wr_slot == AW'(DEPTH - 1)) ? '0 : wr_slot + AW'(1);
      fill         <= (fill < FW'(DEPTH)) ? fill + FW'(1) : fill;
      tick_counter <= tick_counter + 32'd1;
      if (item_q.work_ms > work_budget) begin
        overrun_cnt <= overrun_cnt + 32'd1;
      end
    end
  end

  // Item payload, divider and result registers.
  always_ff @(posedge clk) begin
    third <= {1'b0, third_prod[TW-1:tsjm_pkg::RECIP_3_SHIFT]};
    if (cmd.load) begin
      item_q  <= item;
      pending <= '0;
      over    <= 1'b0;
    end
    if (cmd.exec) begin
      prod    <= 48'(tick_counter) * 48'(eff_period);
      poll_ok <= item_q.now_ms >= start_time;
      dq      <= item_q.now_ms - start_time;
      drem    <= '0;
      div_cnt <= '0;
    end
    if (cmd.late) begin
      over <= item_q.work_ms > work_budget;
    end
    if (cmd.div_step) begin
      drem    <= trial_ge ? trial_sub[15:0] : trial[15:0];
      dq      <= {dq[46:0], trial_ge};
      div_cnt <= div_cnt + 6'd1;
    end
    if (cmd.pend) begin
      if (poll_ok && due > {17'd0, tick_counter}) begin
        pending <= (due_diff[48:32] != 17'd0) ? 32'hFFFF_FFFF : due_diff[31:0];
      end
    end
    if (cmd.take_all) begin
      p95   <= sel_value;
      meets <= sel_value <= p95_budget;
      gap   <= '0;
    end
    if (cmd.take_head) begin
      head_p95 <= sel_value;
    end
    if (cmd.take_tail) begin
      gap <= (head_p95 > sel_value) ? head_p95 - sel_value : sel_value - head_p95;
    end
  end

  tsjm_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (cmd.late),
    .waddr(wr_slot),
    .wdata(late_sat),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  tsjm_sel #(
    .DEPTH(DEPTH)
  ) u_sel (
    .clk    (clk),
    .rst    (rst),
    .go     (sel_go),
    .first  (sel_first),
    .count  (sel_count),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .done   (sel_done),
    .value  (sel_value)
  );

  always_comb begin
    stat.kind          = item_q.kind;
    stat.div_last      = div_cnt == 6'(tsjm_pkg::DIV_STEPS - 1);
    stat.sel_done      = sel_done;
    stat.fill_ge_split = fill >= FW'(tsjm_pkg::MIN_SPLIT);

    result.pending_ticks    = pending;
    result.over_budget      = over;
    result.error_p95_ms     = p95;
    result.meets_budget     = meets;
    result.head_tail_gap_ms = gap;
    result.overrun_count    = overrun_cnt;
    result.skipped_total    = skip_cnt;
  end

  // The fill count never exceeds the ring depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= FW'(DEPTH))
    else $error("ring fill count above depth");

  // Until the ring wraps, the write slot tracks the fill count.
  a_slot_tracks_fill: assert property (@(posedge clk) disable iff (rst)
    (fill < FW'(DEPTH)) |-> ((FW+1)'(wr_slot) == (FW+1)'(fill)))
    else $error("write slot out of step with fill count");

endmodule

/* rtl/tsjm_ctrl.sv */
// Controller state machine sequencing one word through the datapath.
module tsjm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  tsjm_pkg::stat_t stat,
  output logic            busy,
  output logic            done,
  output tsjm_pkg::cmd_t  cmd
);

  tsjm_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsjm_pkg::C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = state != tsjm_pkg::C_IDLE;
    done       = state == tsjm_pkg::C_DONE;
    unique case (state)
      tsjm_pkg::C_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = tsjm_pkg::C_EXEC;
        end
      end
      tsjm_pkg::C_EXEC: begin
        cmd.exec = 1'b1;
        unique case (stat.kind)
          tsjm_pkg::KIND_RUN:   state_next = tsjm_pkg::C_LATE;
          tsjm_pkg::KIND_POLL:  state_next = tsjm_pkg::C_DIV;
          tsjm_pkg::KIND_START,
          tsjm_pkg::KIND_SKIP:  state_next = tsjm_pkg::C_ALL_GO;
          default:              state_next = tsjm_pkg::C_ALL_GO;
        endcase
      end
      tsjm_pkg::C_LATE: begin
        cmd.late   = 1'b1;
        state_next = tsjm_pkg::C_ALL_GO;
      end
      tsjm_pkg::C_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = tsjm_pkg::C_PEND;
        end
      end
      tsjm_pkg::C_PEND: begin
        cmd.pend   = 1'b1;
        state_next = tsjm_pkg::C_ALL_GO;
      end
      tsjm_pkg::C_ALL_GO: begin
        cmd.go_all = 1'b1;
        state_next = tsjm_pkg::C_ALL_WAIT;
      end
      tsjm_pkg::C_ALL_WAIT: begin
        if (stat.sel_done) begin
          cmd.take_all = 1'b1;
          state_next   = stat.fill_ge_split ? tsjm_pkg::C_HEAD_GO : tsjm_pkg::C_DONE;
        end
      end
      tsjm_pkg::C_HEAD_GO: begin
        cmd.go_head = 1'b1;
        state_next  = tsjm_pkg::C_HEAD_WAIT;
      end
      tsjm_pkg::C_HEAD_WAIT: begin
        if (stat.sel_done) begin
          cmd.take_head = 1'b1;
          state_next    = tsjm_pkg::C_TAIL_GO;
        end
      end
      tsjm_pkg::C_TAIL_GO: begin
        cmd.go_tail = 1'b1;
        state_next  = tsjm_pkg::C_TAIL_WAIT;
      end
      tsjm_pkg::C_TAIL_WAIT: begin
        if (stat.sel_done) begin
          cmd.take_tail = 1'b1;
          state_next    = tsjm_pkg::C_DONE;
        end
      end
      tsjm_pkg::C_DONE: state_next = tsjm_pkg::C_IDLE;
      default:          state_next = tsjm_pkg::C_IDLE;
    endcase
  end

  // A result strobe lasts exactly one cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held longer than one cycle");

  // An accepted word always starts execution on the next cycle.
  a_load_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == tsjm_pkg::C_EXEC))
    else $error("accepted word did not enter execution");

endmodule

/* rtl/tick_schedule_jitter_monitor_top.sv */
// Top level of the tick schedule jitter monitor.
// A word first passes through bookkeeping (and, for a poll, a divide that runs
// one quotient bit per cycle), then one P95 selection over n filled slots and,
// from six samples on, two more over n/3 slots each. A selection over m > 0 slots
// makes eight radix-16 passes, each reading every slot through the single ring
// read port and scanning up to 16 buckets. The block takes one word at a time.
// Reset (synchronous) clears all counters and the ring fill, restores the register
// defaults and leaves the block idle. The result strobe cannot be stalled.
module tick_schedule_jitter_monitor_top #(
  parameter int unsigned SAMPLE_DEPTH = tsjm_pkg::SAMPLE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  // Input word: accepted when start is high and busy is low.
  input  logic                           start,
  output logic                           busy,
  input  tsjm_pkg::in_t                  item,
  // Result word: valid for exactly the one cycle that done is high.
  output logic                           done,
  output tsjm_pkg::out_t                 result,
  // Configuration write port, used only while the block is idle.
  input  logic                           cfg_we,
  input  logic [tsjm_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [tsjm_pkg::CFG_W-1:0]     cfg_data
);

  tsjm_pkg::cmd_t  cmd;
  tsjm_pkg::stat_t stat;

  // The controller steps through bookkeeping, the divide for a poll and up to three
  // percentile selections, and raises done once every field is settled.
  tsjm_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .busy (busy),
    .done (done),
    .cmd  (cmd)
  );

  // The datapath holds the schedule state, the lateness ring (with a fill
  // count in place of a clearing pass) and the selection engine.
  tsjm_dp #(
    .DEPTH(SAMPLE_DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .cmd     (cmd),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data),
    .stat    (stat),
    .result  (result)
  );

endmodule

/* sim/tsjm_scoreboard.sv */
// Scoreboard for the tick schedule jitter monitor: predicts each result and compares it.
`timescale 1ns / 1ps
module tsjm_scoreboard
  import tsjm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  in_t                   item,
  input  logic                  done,
  input  out_t                  result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_W-1:0]      cfg_data,
  output int                    errors,
  output int                    outstanding
);

  localparam logic [63:0] SAT32 = 64'hFFFF_FFFF;

  logic [15:0] period;
  logic [31:0] work_budget;
  logic [31:0] p95_budget;

  logic [47:0] t_start;
  logic [31:0] ticks;
  logic [31:0] acc_ticks;
  logic [31:0] last_work;
  logic [31:0] overruns;
  logic [31:0] skipped;
  logic [31:0] lateness [SAMPLE_DEPTH];
  logic [5:0]  wr_slot;
  logic [6:0]  fill;

  out_t expected_results [$];

  function automatic logic [63:0] eff_period();
    return (period == 16'd0) ? 64'd1 : {48'd0, period};
  endfunction

  // Nearest-rank P95 over a run of slots, taken from a sorted copy.
  function automatic logic [31:0] p95_of(int first, int n);
    logic [31:0] buf_q [$];
    logic [31:0] v;
    int j;
    int rank;
    if (n == 0) return 32'd0;
    for (int i = 0; i < n; i++) buf_q.push_back(lateness[first + i]);
    for (int i = 1; i < n; i++) begin
      v = buf_q[i];
      j = i;
      while (j > 0 && buf_q[j-1] > v) begin
        buf_q[j] = buf_q[j-1];
        j--;
      end
      buf_q[j] = v;
    end
    rank = (n * 95 + 99) / 100;
    if (rank < 1) rank = 1;
    if (rank > n) rank = n;
    return buf_q[rank-1];
  endfunction

  function automatic void clear_all();
    t_start = '0;
    ticks = '0;
    acc_ticks = '0;
    last_work = '0;
    overruns = '0;
    skipped = '0;
    for (int i = 0; i < SAMPLE_DEPTH; i++) lateness[i] = '0;
    wr_slot = '0;
    fill = '0;
  endfunction

  function automatic out_t predict(in_t w);
    out_t r;
    logic [63:0] sched;
    logic [63:0] late;
    logic [63:0] due;
    logic [31:0] h;
    logic [31:0] t;
    int n;
    int third;
    r = '0;
    case (w.kind)
      KIND_START: begin
        clear_all();
        t_start = w.now_ms;
      end
      KIND_RUN: begin
        sched = {16'd0, t_start} + {32'd0, ticks} * eff_period();
        late = ({16'd0, w.now_ms} >= sched) ? {16'd0, w.now_ms} - sched
                                            : sched - {16'd0, w.now_ms};
        if (late > SAT32) late = SAT32;
        lateness[wr_slot] = late[31:0];
        wr_slot = wr_slot + 6'd1;
        if (fill < 7'(SAMPLE_DEPTH)) fill = fill + 7'd1;
        ticks = ticks + 32'd1;
        acc_ticks = acc_ticks + 32'd1;
        last_work = w.work_ms;
        if (w.work_ms > work_budget) begin
          r.over_budget = 1'b1;
          overruns = overruns + 32'd1;
        end
      end
      KIND_SKIP: begin
        skipped = skipped + w.skip_ticks;
        acc_ticks = acc_ticks + w.skip_ticks;
      end
      default: begin
        if (w.now_ms >= t_start) begin
          due = {16'd0, w.now_ms - t_start} / eff_period() + 64'd1;
          if (due > {32'd0, ticks}) begin
            due = due - {32'd0, ticks};
            r.pending_ticks = (due > SAT32) ? 32'hFFFF_FFFF : due[31:0];
          end
        end
      end
    endcase
    n = int'(fill);
    r.error_p95_ms = p95_of(0, n);
    r.meets_budget = (r.error_p95_ms <= p95_budget);
    if (n >= 6) begin
      third = n / 3;
      h = p95_of(0, third);
      t = p95_of(n - third, third);
      r.head_tail_gap_ms = (h > t) ? h - t : t - h;
    end
    r.overrun_count = overruns;
    r.skipped_total = skipped;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    out_t e;
    if (rst) begin
      period = PERIOD_RESET;
      work_budget = WORK_BUDGET_RESET;
      p95_budget = P95_BUDGET_RESET;
      clear_all();
      expected_results.delete();
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected, got %p", $time, result);
          errors++;
        end else begin
          e = expected_results.pop_front();
          check_field("pending_ticks", e.pending_ticks, result.pending_ticks);
          check_field("over_budget", 32'(e.over_budget), 32'(result.over_budget));
          check_field("error_p95_ms", e.error_p95_ms, result.error_p95_ms);
          check_field("meets_budget", 32'(e.meets_budget), 32'(result.meets_budget));
          check_field("head_tail_gap_ms", e.head_tail_gap_ms, result.head_tail_gap_ms);
          check_field("overrun_count", e.overrun_count, result.overrun_count);
          check_field("skipped_total", e.skipped_total, result.skipped_total);
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_idx))
          REG_PERIOD:      period = cfg_data[15:0];
          REG_WORK_BUDGET: work_budget = cfg_data;
          REG_P95_BUDGET:  p95_budget = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) expected_results.push_back(predict(item));
    end
    outstanding = expected_results.size();
  end

endmodule

/* sim/tick_schedule_jitter_monitor_top_tb.sv */
// Stimulus and verdict for the tick schedule jitter monitor testbench.
`timescale 1ns / 1ps
module tick_schedule_jitter_monitor_top_tb;
  import tsjm_pkg::*;

  // All words of the run, gaps included, fit well below this limit.
  localparam int CYCLE_LIMIT = 3_000_000;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  in_t                  item;
  logic                 done;
  out_t                 result;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;
  int                   errors;
  int                   outstanding;
  int                   cycles;

  // Percentage of cycles in which the sender holds back before a word.
  int                   idle_pct;

  // The stimulus keeps its own view of the schedule so that most tick runs
  // and polls land near the ideal times and the statistics stay meaningful.
  longint unsigned      sched_base;
  longint unsigned      sched_ticks;
  longint unsigned      sched_period;

  tick_schedule_jitter_monitor_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  tsjm_scoreboard scoreboard (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .errors(errors), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Present one word and hold it until the block takes it. A random gap
  // comes first; start is only lowered when such a gap is actually taken,
  // so it never sees two assignments in one time step.
  task automatic send_word(in_t w);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    item  <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Pause the sender until every expected result has come back and the
  // block has gone idle, then give it a little slack.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
    repeat (20) @(posedge clk);
  endtask

  // Write one register; only called while the block is idle.
  task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
    if (idx == REG_PERIOD) sched_period = (data[15:0] == 16'd0) ? 1 : data[15:0];
  endtask

  function automatic in_t mk(kind_t k, logic [47:0] now, logic [31:0] work,
                             logic [31:0] skip);
    in_t w;
    w.kind = k;
    w.now_ms = now;
    w.work_ms = work;
    w.skip_ticks = skip;
    return w;
  endfunction

  function automatic logic [47:0] rand48();
    return {$urandom(), $urandom()};
  endfunction

  // Time near the next ideal tick: mostly a small jitter either way,
  // sometimes a large one.
  function automatic logic [47:0] near_schedule();
    longint signed jit;
    longint signed t;
    if ($urandom_range(19) == 0) jit = longint'($urandom()) - longint'($urandom());
    else jit = longint'($urandom_range(40)) - 20;
    t = longint'(sched_base + sched_ticks * sched_period) + jit;
    if (t < 0) t = 0;
    return t[47:0];
  endfunction

  // One random word: mostly well-formed schedule traffic, some noise.
  task automatic send_random();
    int pick;
    in_t w;
    pick = $urandom_range(99);
    if (pick < 3) begin
      sched_base = ($urandom_range(9) == 0) ? rand48() : $urandom_range(100000);
      sched_ticks = 0;
      w = mk(KIND_START, sched_base[47:0], $urandom(), $urandom());
    end else if (pick < 63) begin
      w = mk(KIND_RUN, near_schedule(),
             ($urandom_range(3) == 0) ? $urandom() : $urandom_range(30), $urandom());
      sched_ticks++;
    end else if (pick < 73) begin
      w = mk(KIND_SKIP, rand48(), $urandom(),
             ($urandom_range(4) == 0) ? $urandom() : $urandom_range(5));
    end else if (pick < 90) begin
      w = mk(KIND_POLL, near_schedule() + $urandom_range(3) * sched_period[47:0],
             $urandom(), $urandom());
    end else begin
      // Noise: every field fully random, including the kind.
      w = mk(kind_t'($urandom_range(3)), rand48(), $urandom(), $urandom());
      if (w.kind == KIND_START) begin
        sched_base = w.now_ms;
        sched_ticks = 0;
      end else if (w.kind == KIND_RUN) begin
        sched_ticks++;
      end
    end
    send_word(w);
  endtask

  initial begin
    cycles   = 0;
    rst      = 1'b1;
    start    = 1'b0;
    item     = '0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    idle_pct = 34;
    sched_base = 0;
    sched_ticks = 0;
    sched_period = 50;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, run with the reset register values first.
    send_word(mk(KIND_POLL, 48'd0, 32'd0, 32'd0));             // empty ring
    send_word(mk(KIND_START, 48'd1000, 32'd0, 32'd0));
    send_word(mk(KIND_POLL, 48'd900, 32'd0, 32'd0));           // poll before start
    send_word(mk(KIND_RUN, 48'd1000, 32'd10, 32'd0));          // on time, at budget
    send_word(mk(KIND_RUN, 48'd1055, 32'd11, 32'd0));          // late, over budget
    send_word(mk(KIND_RUN, 48'd1090, 32'hFFFF_FFFF, 32'd0));   // early
    send_word(mk(KIND_POLL, 48'd1400, 32'd0, 32'd0));
    send_word(mk(KIND_SKIP, 48'd0, 32'd0, 32'hFFFF_FFFF));
    send_word(mk(KIND_SKIP, 48'd0, 32'd0, 32'd2));             // skip counter wraps
    send_word(mk(KIND_RUN, 48'hFFFF_FFFF_FFFF, 32'd0, 32'd0)); // lateness saturates
    send_word(mk(KIND_RUN, 48'd1200, 32'd3, 32'd0));
    send_word(mk(KIND_RUN, 48'd1260, 32'd3, 32'd0));
    send_word(mk(KIND_RUN, 48'd1290, 32'd3, 32'd0));
    send_word(mk(KIND_RUN, 48'd1350, 32'd3, 32'd0));           // enough for the gap
    drain();
    write_reg(REG_PERIOD, 32'd0);                              // zero period acts as one
    write_reg(REG_WORK_BUDGET, 32'd0);
    write_reg(REG_P95_BUDGET, 32'hFFFF_FFFF);
    send_word(mk(KIND_START, 48'd0, 32'd0, 32'd0));
    send_word(mk(KIND_POLL, 48'hFFFF_FFFF_FFFF, 32'd0, 32'd0)); // pending saturates
    send_word(mk(KIND_RUN, 48'd5, 32'd1, 32'd0));
    send_word(mk(KIND_RUN, 48'd0, 32'd0, 32'd0));
    send_word(mk(KIND_POLL, 48'd100, 32'd0, 32'd0));
    send_word(mk(KIND_START, 48'hFFFF_FFFF_FFFF, 32'd0, 32'd0));
    send_word(mk(KIND_POLL, 48'd0, 32'd0, 32'd0));
    drain();
    sched_base = 48'hFFFF_FFFF_FFFF;
    sched_ticks = 0;

    // Random phase one: middling settings, sender idles often.
    write_reg(REG_PERIOD, $urandom_range(200, 1));
    write_reg(REG_WORK_BUDGET, $urandom_range(20));
    write_reg(REG_P95_BUDGET, $urandom_range(15));
    repeat (150) send_random();
    drain();

    // Random phase two: largest period and budgets, sender idles more.
    idle_pct = 66;
    write_reg(REG_PERIOD, 32'd65535);
    write_reg(REG_WORK_BUDGET, 32'hFFFF_FFFF);
    write_reg(REG_P95_BUDGET, 32'hFFFF_FFFF);
    repeat (150) send_random();
    drain();

    // Random phase three: smallest settings, words back to back.
    idle_pct = 0;
    write_reg(REG_PERIOD, 32'd1);
    write_reg(REG_WORK_BUDGET, 32'd0);
    write_reg(REG_P95_BUDGET, 32'd0);
    repeat (150) send_random();
    drain();

    if (errors == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/tsjm_pkg.sv
rtl/tsjm_ram.sv
rtl/tsjm_sel.sv
rtl/tsjm_dp.sv
rtl/tsjm_ctrl.sv
rtl/tick_schedule_jitter_monitor_top.sv
sim/tsjm_scoreboard.sv
sim/tick_schedule_jitter_monitor_top_tb.sv
